[sv/iblt_pkg.sv]
// ----------------------------------------------------------------------------
// IBLT package
// Shared types, constants and hash helpers for the lookup table block.
// ----------------------------------------------------------------------------
package iblt_pkg;

  localparam int MaxBuckets = 64;
  localparam int HashCount  = 3;
  localparam int CellTotal  = HashCount * MaxBuckets;
  localparam int IdxW       = $clog2(CellTotal);
  localparam int BktW       = $clog2(MaxBuckets + 1);
  localparam logic [31:0] CheckSeed = 32'd11;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_ERASE    = 3'd1,
    OP_WRITE    = 3'd2,
    OP_SUBTRACT = 3'd3,
    OP_READ     = 3'd4,
    OP_PEEL     = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [31:0]        key;
    logic [7:0]         cell_index;
    logic signed [31:0] cell_count;
    logic [31:0]        cell_key_sum;
    logic [31:0]        cell_check_sum;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic               is_negative;
    logic               decoded_all;
    logic [31:0]        out_key;
    logic signed [31:0] out_count;
    logic [31:0]        out_check;
  } out_item_t;

  // datapath commands
  typedef enum logic [3:0] {
    DC_NONE, DC_LATCH, DC_HASH_LOAD, DC_HASH_STEP, DC_IDX, DC_RD,
    DC_RMW, DC_WRITE, DC_SUB, DC_READ_OUT, DC_SCAN_RD, DC_SCAN_EVAL, DC_RESULT,
    DC_MOD
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] sel;       // hash seed or lane
    logic       clear;     // clear pass write
  } dp_cmd_t;

  typedef struct packed {
    logic hash_done;
    logic scan_last;
    logic pure_hit;
    logic pure_now;
    logic mod_last;
    logic in_store;
    logic clr_last;
  } dp_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

endpackage

[sv/iblt_hash.sv]
// ----------------------------------------------------------------------------
// IBLT hash unit
// Multicycle MurmurHash3 of one 32-bit word, one multiply per cycle.
// ----------------------------------------------------------------------------
module iblt_hash import iblt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] seed,
  input  logic [31:0] word,
  output logic        done,
  output logic [31:0] hash
);

  logic [2:0]  step;
  logic        busy;
  logic [31:0] k;
  logic [31:0] h;
  logic [31:0] h1;

  assign h1 = rotl(h ^ k, 13);
  assign hash = h;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        k <= word * 32'hcc9e2d51;
        h <= seed;
      end else if (busy) begin
        step <= step + 3'd1;
        unique case (step)
          3'd0: k <= rotl(k, 15) * 32'h1b873593;
          3'd1: h <= (h1 * 32'd5 + 32'he6546b64) ^ 32'd4;
          3'd2: h <= (h ^ (h >> 16)) * 32'h85ebca6b;
          3'd3: h <= (h ^ (h >> 13)) * 32'hc2b2ae35;
          3'd4: begin
            h <= h ^ (h >> 16);
            busy <= 1'b0;
            done <= 1'b1;
          end
          default: busy <= 1'b0;
        endcase
      end
    end
  end

endmodule

[sv/iblt_datapath.sv]
// ----------------------------------------------------------------------------
// IBLT datapath
// Cell memory, operand registers, hash unit and result register.
// ----------------------------------------------------------------------------
module iblt_datapath import iblt_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  in_item_t        in_item,
  input  logic [6:0]      buckets,
  input  dp_cmd_t         cmd,
  output dp_stat_t        stat,
  output out_item_t       result
);

  logic [95:0] mem [CellTotal];
  logic [95:0] rd;
  logic [IdxW-1:0] addr;
  logic [IdxW-1:0] scan;
  logic [IdxW-1:0] clr;

  in_item_t    item;
  logic [31:0] akey;
  logic [31:0] delta;
  logic [31:0] chk;
  logic        hstart;
  logic [31:0] hseed;
  logic [31:0] hword;
  logic        hdone;
  logic [31:0] hval;
  logic [BktW-1:0] eb;
  logic [IdxW-1:0] used_last;
  logic        empty;
  logic        hit;
  logic        neg;
  logic        pure_now;
  logic [31:0] mq;
  logic [6:0]  mrem;
  logic [6:0]  mr;
  logic [2:0]  mcnt;
  out_item_t   res_next;

  assign eb = (buckets == 7'd0) ? BktW'(1) :
              (buckets > 7'(MaxBuckets)) ? BktW'(MaxBuckets) : BktW'(buckets);
  assign used_last = IdxW'(HashCount * eb - 1);

  iblt_hash u_hash (
    .clk(clk), .rst(rst), .start(hstart), .seed(hseed), .word(hword),
    .done(hdone), .hash(hval)
  );

  assign hstart = (cmd.op == DC_HASH_LOAD);
  assign hseed  = (cmd.sel == 2'd3) ? CheckSeed : 32'(cmd.sel);
  assign hword  = (cmd.op == DC_HASH_LOAD && cmd.clear) ? rd[63:32] : akey;

  assign pure_now = (rd[95:64] == 32'd1 || rd[95:64] == 32'hffffffff) &&
                    (rd[31:0] == hval);

  // reduce four hash bits per cycle by the bucket count
  always_comb begin
    mr = mrem;
    for (int b = 0; b < 4; b++) begin
      mr = {mr[5:0], mq[31 - b]};
      if (mr >= 7'(eb)) mr = mr - 7'(eb);
    end
  end

  assign stat.hash_done = hdone;
  assign stat.scan_last = (scan == used_last);
  assign stat.pure_hit  = hit;
  assign stat.pure_now  = pure_now;
  assign stat.mod_last  = (mcnt == 3'd7);
  assign stat.in_store  = (item.cell_index < 8'(CellTotal));
  assign stat.clr_last  = (clr == IdxW'(CellTotal - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.op == DC_NONE && cmd.clear) begin
      mem[clr] <= '0;
      clr <= clr + IdxW'(1);
    end else begin
      unique case (cmd.op)
        DC_LATCH: begin
          item  <= in_item;
          akey  <= in_item.key;
          delta <= (in_item.opcode == OP_ERASE) ? 32'hffffffff : 32'd1;
          scan  <= '0;
          empty <= 1'b1;
          hit   <= 1'b0;
        end
        DC_HASH_STEP: if (hdone) begin
          if (cmd.sel == 2'd3) chk <= hval;
          else begin
            mq   <= hval;
            mrem <= '0;
            mcnt <= '0;
          end
        end
        DC_MOD: begin
          mq   <= mq << 4;
          mrem <= mr;
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd7) addr <= IdxW'(cmd.sel) * IdxW'(eb) + IdxW'(mr);
        end
        DC_IDX: addr <= item.cell_index[IdxW-1:0];
        DC_RD: rd <= mem[addr];
        DC_RMW: mem[addr] <= {rd[95:64] + delta, rd[63:32] ^ akey, rd[31:0] ^ chk};
        DC_WRITE: mem[addr] <= {item.cell_count, item.cell_key_sum, item.cell_check_sum};
        DC_SUB: mem[addr] <= {rd[95:64] - item.cell_count, rd[63:32] ^ item.cell_key_sum,
                              rd[31:0] ^ item.cell_check_sum};
        DC_SCAN_RD: rd <= mem[scan];
        DC_SCAN_EVAL: begin
          if (hdone) begin
            if (pure_now) begin
              hit   <= 1'b1;
              neg   <= rd[95];
              akey  <= rd[63:32];
              delta <= 32'd0 - rd[95:64];
            end
            if (rd != '0) empty <= 1'b0;
            if (scan != used_last) scan <= scan + IdxW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_next = '0;
    if (item.opcode == OP_READ && stat.in_store) begin
      res_next.out_key   = rd[63:32];
      res_next.out_count = rd[95:64];
      res_next.out_check = rd[31:0];
    end else if (item.opcode == OP_PEEL) begin
      res_next.found       = hit;
      res_next.is_negative = hit & neg;
      res_next.out_key     = hit ? akey : 32'd0;
      res_next.decoded_all = ~hit & empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DC_RESULT) result <= res_next;
  end

endmodule

[sv/iblt_ctrl.sv]
// ----------------------------------------------------------------------------
// IBLT controller
// Sequences clearing, hashing, read-modify-writes, scans and results.
// ----------------------------------------------------------------------------
module iblt_ctrl import iblt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic [2:0] in_op,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output dp_cmd_t   cmd,
  input  dp_stat_t  stat
);

  typedef enum logic [13:0] {
    S_CLR  = 14'b00000000000001, S_IDLE = 14'b00000000000010,
    S_HLD  = 14'b00000000000100, S_HWT  = 14'b00000000001000,
    S_RD   = 14'b00000000010000, S_RMW  = 14'b00000000100000,
    S_CRD  = 14'b00000001000000, S_CWR  = 14'b00000010000000,
    S_PRD  = 14'b00000100000000, S_PHL  = 14'b00001000000000,
    S_PEV  = 14'b00010000000000, S_RES  = 14'b00100000000000,
    S_OUT  = 14'b01000000000000, S_MOD  = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic [1:0] lane, lane_next;
  op_t op, op_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      lane  <= '0;
      op    <= OP_INSERT;
    end else begin
      state <= state_next;
      lane  <= lane_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    lane_next  = lane;
    op_next    = op;
    cmd        = '{op: DC_NONE, sel: lane, clear: 1'b0};
    unique case (state)
      S_CLR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: if (in_valid) begin
        cmd.op  = DC_LATCH;
        op_next = op_t'(in_op);
        unique case (in_op)
          OP_INSERT, OP_ERASE: begin
            lane_next = 2'd3;
            state_next = S_HLD;
          end
          OP_WRITE, OP_SUBTRACT, OP_READ: state_next = S_CRD;
          OP_PEEL: state_next = S_PRD;
          default: state_next = S_RES;
        endcase
      end
      S_HLD: begin
        cmd.op = DC_HASH_LOAD;
        state_next = S_HWT;
      end
      S_HWT: begin
        cmd.op = DC_HASH_STEP;
        if (stat.hash_done) begin
          if (lane == 2'd3) begin
            lane_next = 2'd0;
            state_next = S_HLD;
          end else state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.op = DC_MOD;
        if (stat.mod_last) state_next = S_RD;
      end
      S_RD: begin
        cmd.op = DC_RD;
        state_next = S_RMW;
      end
      S_RMW: begin
        cmd.op = DC_RMW;
        if (lane == 2'd2) state_next = S_RES;
        else begin
          lane_next = lane + 2'd1;
          state_next = S_HLD;
        end
      end
      S_CRD: begin
        cmd.op = stat.in_store ? DC_IDX : DC_NONE;
        state_next = stat.in_store ? S_CWR : S_RES;
      end
      S_CWR: begin
        cmd.op = DC_RD;
        state_next = S_RES;
      end
      S_PRD: begin
        cmd.op = DC_SCAN_RD;
        state_next = S_PHL;
      end
      S_PHL: begin
        cmd.op = DC_HASH_LOAD;
        cmd.sel = 2'd3;
        cmd.clear = 1'b1;
        state_next = S_PEV;
      end
      S_PEV: begin
        cmd.op = DC_SCAN_EVAL;
        if (stat.hash_done) begin
          if (stat.pure_now || stat.scan_last) state_next = S_RES;
          else state_next = S_PRD;
        end
      end
      S_RES: begin
        if (op == OP_PEEL && stat.pure_hit && lane != 2'd2) begin
          lane_next = 2'd3;
          state_next = S_HLD;
        end else if ((op == OP_WRITE || op == OP_SUBTRACT) && stat.in_store &&
                     lane != 2'd1) begin
          cmd.op = (op == OP_WRITE) ? DC_WRITE : DC_SUB;
          lane_next = 2'd1;
        end else begin
          cmd.op = DC_RESULT;
          state_next = S_OUT;
        end
      end
      S_OUT: if (!out_stall) begin
        state_next = S_IDLE;
        lane_next = 2'd0;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[sv/iblt_insert_erase_peel.sv]
// ----------------------------------------------------------------------------
// IBLT insert/erase/peel
// Three-hash invertible Bloom lookup table with cell access and peeling.
// ----------------------------------------------------------------------------
// One transaction at a time; input stalls from acceptance until the result is
// taken. Insert and erase run four MurmurHash3 passes on one shared hash unit
// (the check hash, then one per sub-table), a remainder by the bucket count
// per sub-table at four bits a cycle, three cell read-modify-writes and the
// result. Cell write and subtract read the indexed cell and then write it,
// read only reads it, and a cell index out of storage or an unused opcode
// goes straight to the result. Peel scans the cells, running the check hash
// of each, until a cell is pure or the last used cell is reached, and removes
// a pure cell's key from the table. Input is accepted again in the cycle after
// the result is taken. After reset every cell of the table is cleared, during
// which input is stalled.
module iblt_insert_erase_peel import iblt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  logic [6:0] buckets;
  dp_cmd_t    cmd;
  dp_stat_t   stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) buckets <= 7'(MaxBuckets);
    else if (cfg_valid) buckets <= cfg_data;
  end

  iblt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_op(in_data.opcode),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .stat(stat)
  );

  iblt_datapath u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .buckets(buckets),
    .cmd(cmd), .stat(stat), .result(out_data)
  );

endmodule
